// ----- rtl/core/teup_pkg.sv -----
// types and constants of the terminal escape and utf-8 parser
// no dependencies; imported by terminal_escape_utf8_parser_core
`default_nettype none

package teup_pkg;

  typedef enum logic [2:0] {
    ModeGround,
    ModeEsc,
    ModeCsi,
    ModeCsiSkip,
    ModeOsc,
    ModeOscEsc,
    ModeOscSkip,
    ModeOscSkipEsc
  } mode_e;

  localparam logic [3:0] KindPrint   = 4'd0;
  localparam logic [3:0] KindCr      = 4'd1;
  localparam logic [3:0] KindLf      = 4'd2;
  localparam logic [3:0] KindBs      = 4'd3;
  localparam logic [3:0] KindTab     = 4'd4;
  localparam logic [3:0] KindEscape  = 4'd5;
  localparam logic [3:0] KindCsi     = 4'd6;
  localparam logic [3:0] KindOsc     = 4'd7;
  localparam logic [3:0] KindUnknown = 4'd8;
  localparam logic [3:0] KindPayload = 4'd9;

  localparam logic [1:0] ClsCsiOverflow = 2'd0;
  localparam logic [1:0] ClsOscOverflow = 2'd1;
  localparam logic [1:0] ClsBadUtf8     = 2'd2;

  localparam logic [7:0]  EscByte     = 8'h1b;
  localparam logic [7:0]  BelByte     = 8'h07;
  localparam logic [7:0]  CsiOpen     = 8'h5b;
  localparam logic [7:0]  OscOpen     = 8'h5d;
  localparam logic [7:0]  StByte      = 8'h5c;
  localparam logic [20:0] Replacement = 21'h00fffd;

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] cp;
    logic [7:0]  fin;
    logic [1:0]  cls;
    logic [15:0] len;
    logic [7:0]  pv;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        to_esc;
    logic        emit;
    logic [3:0]  kind;
    logic [20:0] cp;
    logic        bad;
    logic        set_pend;
    logic [1:0]  pend;
    logic [20:0] partial;
  } gb_t;

endpackage

`default_nettype wire

// ----- rtl/core/terminal_escape_utf8_parser_core.sv -----
// terminal byte stream parser: ground text with utf-8, escape, csi and osc
// sequences; payload bytes sit in a one-port synchronous store
// depends on teup_pkg
`default_nettype none

// Takes one byte per item and returns its result items, one per cycle while the
// output is not stalled, through a four-entry output queue. A byte that causes
// zero or one item is taken every cycle while the queue has room; a byte that
// causes more items holds the input until the item issue sequencer issues its
// last item. A closing csi or osc byte sends each buffered payload byte as its
// own item, one per cycle from the payload store read port while the queue has
// room, then the operation item with last_of_run set. There is no clearing pass
// after reset: only payload entries written since the sequence opened are read.
module terminal_escape_utf8_parser_core #(
  parameter int CSI_MAX_BYTES = 32,
  parameter int OSC_MAX_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       item_kind_o,
  output logic [20:0]      code_point_o,
  output logic [7:0]       final_code_o,
  output logic [1:0]       unknown_class_o,
  output logic [15:0]      discard_length_o,
  output logic [7:0]       payload_value_o,
  output logic             last_of_run_o
);
  import teup_pkg::*;

  localparam int Depth = (CSI_MAX_BYTES > OSC_MAX_BYTES) ? CSI_MAX_BYTES : OSC_MAX_BYTES;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [5:0] CsiMax = 6'(CSI_MAX_BYTES);
  localparam logic [5:0] OscMax = 6'(OSC_MAX_BYTES);

  function automatic gb_t ground_byte(input logic [7:0] b);
    gb_t g;
    g = '0;
    if (b == EscByte) begin
      g.to_esc = 1'b1;
    end else if (b == 8'h0d) begin
      g.emit = 1'b1;
      g.kind = KindCr;
    end else if (b == 8'h0a) begin
      g.emit = 1'b1;
      g.kind = KindLf;
    end else if (b == 8'h08) begin
      g.emit = 1'b1;
      g.kind = KindBs;
    end else if (b == 8'h09) begin
      g.emit = 1'b1;
      g.kind = KindTab;
    end else if (b >= 8'h20 && b < 8'h7f) begin
      g.emit = 1'b1;
      g.kind = KindPrint;
      g.cp = {13'd0, b};
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      g.set_pend = 1'b1;
      g.pend = 2'd1;
      g.partial = {16'd0, b[4:0]};
    end else if (b >= 8'he0 && b <= 8'hef) begin
      g.set_pend = 1'b1;
      g.pend = 2'd2;
      g.partial = {17'd0, b[3:0]};
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      g.set_pend = 1'b1;
      g.pend = 2'd3;
      g.partial = {18'd0, b[2:0]};
    end else if (b >= 8'h80) begin
      g.bad = 1'b1;
    end
    return g;
  endfunction

  function automatic logic [5:0] cnt_add1(input logic [5:0] v);
    return v + 6'd1;
  endfunction

  // parser state
  mode_e       mode_q, mode_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [15:0] skip_q, skip_d;
  logic [1:0]  pend_q, pend_d;
  logic [20:0] part_q, part_d;

  // payload store
  logic [7:0]    mem [Depth];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [7:0]    rdata_q;

  // job of the last accepted byte
  logic [1:0] pairs_q, pairs_d, nj_pairs;
  logic       half_q, half_d;
  logic [5:0] idx_q, idx_d;
  logic [5:0] n_q, n_d, nj_n;
  logic       tail_v_q, tail_v_d, nj_tail_v;
  item_t      tail_q, tail_d, nj_tail;

  // issue stage and output queue
  logic       s1_valid_q;
  logic       s1_mem_q;
  item_t      s1_q;
  logic       issue, issue_last, issue_mem, busy, room;
  item_t      issue_item;
  item_t      fifo_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] fcnt_q;
  logic       push, pop;
  item_t      push_item;

  logic        accept;
  gb_t         g;
  logic [20:0] part_n;
  logic [15:0] skip_inc;
  logic [5:0]  cnt_p1;

  assign busy = (pairs_q != 2'd0) || (idx_q != n_q) || tail_v_q;
  assign room = (fcnt_q + {2'd0, s1_valid_q}) <= 3'd3;
  assign issue = busy && room;
  assign in_stall_o = busy && !(issue && issue_last);
  assign accept = in_valid_i && !in_stall_o;

  assign part_n   = {part_q[14:0], data_byte_i[5:0]};
  assign skip_inc = (skip_q == 16'hffff) ? skip_q : skip_q + 16'd1;
  assign cnt_p1   = cnt_q + 6'd1;

  // next parser state and job
  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    skip_d    = skip_q;
    pend_d    = pend_q;
    part_d    = part_q;
    wr_en     = 1'b0;
    wr_addr   = cnt_q[AW-1:0];
    wr_data   = data_byte_i;
    nj_pairs  = 2'd0;
    nj_n      = 6'd0;
    nj_tail_v = 1'b0;
    nj_tail   = '0;
    g         = ground_byte(data_byte_i);
    case (mode_q)
      ModeGround: begin
        if (pend_q != 2'd0 && data_byte_i[7:6] == 2'b10) begin
          pend_d = pend_q - 2'd1;
          part_d = part_n;
          if (pend_q == 2'd1) begin
            nj_tail_v    = 1'b1;
            nj_tail.kind = KindPrint;
            nj_tail.cp   = part_n;
            part_d       = '0;
          end
        end else begin
          if (pend_q != 2'd0) begin
            nj_pairs = 2'd1;
            pend_d   = 2'd0;
            part_d   = '0;
          end
          if (g.bad) begin
            nj_pairs = nj_pairs + 2'd1;
          end
          if (g.emit) begin
            nj_tail_v    = 1'b1;
            nj_tail.kind = g.kind;
            nj_tail.cp   = g.cp;
          end
          if (g.to_esc) begin
            mode_d = ModeEsc;
          end
          if (g.set_pend) begin
            pend_d = g.pend;
            part_d = g.partial;
          end
        end
      end
      ModeEsc: begin
        if (data_byte_i == CsiOpen) begin
          cnt_d  = '0;
          mode_d = ModeCsi;
        end else if (data_byte_i == OscOpen) begin
          cnt_d  = '0;
          mode_d = ModeOsc;
        end else begin
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindEscape;
          nj_tail.fin  = data_byte_i;
          mode_d       = ModeGround;
          skip_d       = '0;
        end
      end
      ModeCsi: begin
        if (data_byte_i >= 8'h40 && data_byte_i <= 8'h7e) begin
          nj_n         = cnt_q;
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindCsi;
          nj_tail.fin  = data_byte_i;
          cnt_d        = '0;
          mode_d       = ModeGround;
          skip_d       = '0;
        end else if (cnt_q >= CsiMax) begin
          skip_d = {10'd0, cnt_p1};
          cnt_d  = '0;
          mode_d = ModeCsiSkip;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_p1;
        end
      end
      ModeCsiSkip: begin
        skip_d = skip_inc;
        if (data_byte_i >= 8'h40 && data_byte_i <= 8'h7e) begin
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindUnknown;
          nj_tail.fin  = data_byte_i;
          nj_tail.cls  = ClsCsiOverflow;
          nj_tail.len  = skip_inc;
          mode_d       = ModeGround;
          skip_d       = '0;
        end
      end
      ModeOsc: begin
        if (data_byte_i == BelByte) begin
          nj_n         = cnt_q;
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindOsc;
          cnt_d        = '0;
          mode_d       = ModeGround;
          skip_d       = '0;
        end else if (data_byte_i == EscByte) begin
          // park esc past the fill mark; it only counts if the next byte keeps it
          wr_en   = cnt_q < OscMax;
          wr_data = EscByte;
          mode_d  = ModeOscEsc;
        end else if (cnt_q >= OscMax) begin
          skip_d = {10'd0, cnt_p1};
          cnt_d  = '0;
          mode_d = ModeOscSkip;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_p1;
        end
      end
      ModeOscEsc: begin
        if (data_byte_i == StByte) begin
          nj_n         = cnt_q;
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindOsc;
          cnt_d        = '0;
          mode_d       = ModeGround;
          skip_d       = '0;
        end else if (cnt_p1 >= OscMax) begin
          skip_d = {10'd0, cnt_q} + 16'd2;
          cnt_d  = '0;
          mode_d = ModeOscSkip;
        end else begin
          wr_en   = 1'b1;
          wr_addr = cnt_p1[AW-1:0];
          cnt_d   = cnt_q + 6'd2;
          mode_d  = ModeOsc;
        end
      end
      ModeOscSkip: begin
        skip_d = skip_inc;
        if (data_byte_i == BelByte) begin
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindUnknown;
          nj_tail.cls  = ClsOscOverflow;
          nj_tail.len  = skip_inc;
          mode_d       = ModeGround;
          skip_d       = '0;
        end else if (data_byte_i == EscByte) begin
          mode_d = ModeOscSkipEsc;
        end
      end
      ModeOscSkipEsc: begin
        skip_d = skip_inc;
        if (data_byte_i == StByte) begin
          nj_tail_v    = 1'b1;
          nj_tail.kind = KindUnknown;
          nj_tail.cls  = ClsOscOverflow;
          nj_tail.len  = skip_inc;
          mode_d       = ModeGround;
          skip_d       = '0;
        end else begin
          mode_d = ModeOscSkip;
        end
      end
      default: begin
        mode_d = ModeGround;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeGround;
      cnt_q  <= '0;
      skip_q <= '0;
      pend_q <= '0;
      part_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
  end

  // issue sequencer: bad utf-8 pairs, then payload bytes, then the closing item
  always_comb begin
    pairs_d    = pairs_q;
    half_d     = half_q;
    idx_d      = idx_q;
    n_d        = n_q;
    tail_v_d   = tail_v_q;
    tail_d     = tail_q;
    issue_item = '0;
    issue_last = 1'b0;
    issue_mem  = 1'b0;
    rd_en      = 1'b0;
    if (pairs_q != 2'd0) begin
      if (!half_q) begin
        issue_item.kind = KindUnknown;
        issue_item.cls  = ClsBadUtf8;
        issue_item.len  = 16'd1;
      end else begin
        issue_item.kind = KindPrint;
        issue_item.cp   = Replacement;
        issue_last      = (pairs_q == 2'd1) && (idx_q == n_q) && !tail_v_q;
      end
      if (issue) begin
        half_d = !half_q;
        if (half_q) begin
          pairs_d = pairs_q - 2'd1;
        end
      end
    end else if (idx_q != n_q) begin
      issue_item.kind = KindPayload;
      issue_mem       = 1'b1;
      issue_last      = (cnt_add1(idx_q) == n_q) && !tail_v_q;
      rd_en           = issue;
      if (issue) begin
        idx_d = idx_q + 6'd1;
      end
    end else begin
      issue_item = tail_q;
      issue_last = 1'b1;
      if (issue) begin
        tail_v_d = 1'b0;
      end
    end
    issue_item.last = issue_last;
    if (accept) begin
      pairs_d  = nj_pairs;
      half_d   = 1'b0;
      idx_d    = '0;
      n_d      = nj_n;
      tail_v_d = nj_tail_v;
      tail_d   = nj_tail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q  <= '0;
      half_q   <= 1'b0;
      idx_q    <= '0;
      n_q      <= '0;
      tail_v_q <= 1'b0;
    end else begin
      pairs_q  <= pairs_d;
      half_q   <= half_d;
      idx_q    <= idx_d;
      n_q      <= n_d;
      tail_v_q <= tail_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    if (issue) begin
      s1_q     <= issue_item;
      s1_mem_q <= issue_mem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  // output queue
  always_comb begin
    push_item = s1_q;
    if (s1_mem_q) begin
      push_item.pv = rdata_q;
    end
  end

  assign push = s1_valid_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fcnt_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 2'd1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 2'd1;
      end
      fcnt_q <= fcnt_q + {2'd0, push} - {2'd0, pop};
    end
  end

  assign out_valid_o      = fcnt_q != 3'd0;
  assign item_kind_o      = fifo_q[rptr_q].kind;
  assign code_point_o     = fifo_q[rptr_q].cp;
  assign final_code_o     = fifo_q[rptr_q].fin;
  assign unknown_class_o  = fifo_q[rptr_q].cls;
  assign discard_length_o = fifo_q[rptr_q].len;
  assign payload_value_o  = fifo_q[rptr_q].pv;
  assign last_of_run_o    = fifo_q[rptr_q].last;

endmodule

`default_nettype wire

// ----- tb/terminal_escape_utf8_parser_core_test.sv -----
// self-checking testbench for terminal_escape_utf8_parser_core: random and directed byte streams
// with a scoreboard class that predicts every result item; depends on teup_pkg and the core rtl

import teup_pkg::*;

localparam logic [7:0] CrByte  = 8'h0d;
localparam logic [7:0] LfByte  = 8'h0a;
localparam logic [7:0] BsByte  = 8'h08;
localparam logic [7:0] TabByte = 8'h09;
localparam logic [7:0] DelByte = 8'h7f;

class parse_scoreboard;
  int unsigned csi_max;
  int unsigned osc_max;
  mode_e       mode;
  logic [7:0]  payload_mem[64];
  int unsigned payload_len;
  int unsigned skip_len;
  int unsigned utf8_left;
  logic [20:0] utf8_acc;
  item_t       due[$];
  int          run_start;
  int          errors;
  int          seen[16];

  function new(int unsigned csi_limit, int unsigned osc_limit);
    csi_max = csi_limit;
    osc_max = osc_limit;
    mode = ModeGround;
    payload_len = 0;
    skip_len = 0;
    utf8_left = 0;
    utf8_acc = '0;
    errors = 0;
    foreach (seen[i]) seen[i] = 0;
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void emit(logic [3:0] kind, logic [20:0] cp, logic [7:0] fin, logic [1:0] cls,
                     logic [15:0] len, logic [7:0] pv);
    item_t it;
    if (due.size() - run_start >= 63) return;
    it.kind = kind;
    it.cp = cp;
    it.fin = fin;
    it.cls = cls;
    it.len = len;
    it.pv = pv;
    it.last = 1'b0;
    due.insert(due.size(), it);
  endfunction

  function void bad_utf8();
    emit(KindUnknown, '0, '0, ClsBadUtf8, 16'd1, '0);
    emit(KindPrint, Replacement, '0, '0, '0, '0);
  endfunction

  function void to_ground();
    mode = ModeGround;
    skip_len = 0;
    utf8_left = 0;
    utf8_acc = '0;
  endfunction

  function void bump_skip();
    if (skip_len < 16'hffff) skip_len++;
  endfunction

  function bit is_final(logic [7:0] b);
    return b >= 8'h40 && b <= 8'h7e;
  endfunction

  function void put_byte(logic [7:0] b);
    payload_mem[payload_len & 63] = b;
    payload_len = (payload_len + 1) & 63;
  endfunction

  function void drain();
    for (int i = 0; i < payload_len; i++) emit(KindPayload, '0, '0, '0, '0, payload_mem[i]);
    payload_len = 0;
  endfunction

  function void ground_byte(logic [7:0] b);
    if (b == EscByte) mode = ModeEsc;
    else if (b == CrByte) emit(KindCr, '0, '0, '0, '0, '0);
    else if (b == LfByte) emit(KindLf, '0, '0, '0, '0, '0);
    else if (b == BsByte) emit(KindBs, '0, '0, '0, '0, '0);
    else if (b == TabByte) emit(KindTab, '0, '0, '0, '0, '0);
    else if (b >= 8'h20 && b < DelByte) emit(KindPrint, {13'd0, b}, '0, '0, '0, '0);
    else if (b >= 8'hc2 && b <= 8'hdf) begin
      utf8_acc = {16'd0, b[4:0]};
      utf8_left = 1;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      utf8_acc = {17'd0, b[3:0]};
      utf8_left = 2;
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      utf8_acc = {18'd0, b[2:0]};
      utf8_left = 3;
    end else if (b >= 8'h80) bad_utf8();
  endfunction

  function void take_byte(logic [7:0] b);
    run_start = due.size();
    case (mode)
      ModeGround: begin
        if (utf8_left == 0) ground_byte(b);
        else if (b[7:6] == 2'b10) begin
          utf8_acc = {utf8_acc[14:0], b[5:0]};
          utf8_left--;
          if (utf8_left == 0) begin
            emit(KindPrint, utf8_acc, '0, '0, '0, '0);
            utf8_acc = '0;
          end
        end else begin
          bad_utf8();
          utf8_left = 0;
          utf8_acc = '0;
          ground_byte(b);
        end
      end
      ModeEsc: begin
        if (b == CsiOpen) begin
          payload_len = 0;
          mode = ModeCsi;
        end else if (b == OscOpen) begin
          payload_len = 0;
          mode = ModeOsc;
        end else begin
          emit(KindEscape, '0, b, '0, '0, '0);
          to_ground();
        end
      end
      ModeCsi: begin
        if (is_final(b)) begin
          drain();
          emit(KindCsi, '0, b, '0, '0, '0);
          to_ground();
        end else if (payload_len >= csi_max) begin
          skip_len = payload_len + 1;
          payload_len = 0;
          mode = ModeCsiSkip;
        end else put_byte(b);
      end
      ModeCsiSkip: begin
        bump_skip();
        if (is_final(b)) begin
          emit(KindUnknown, '0, b, ClsCsiOverflow, skip_len[15:0], '0);
          to_ground();
        end
      end
      ModeOsc: begin
        if (b == BelByte) begin
          drain();
          emit(KindOsc, '0, '0, '0, '0, '0);
          to_ground();
        end else if (b == EscByte) mode = ModeOscEsc;
        else if (payload_len >= osc_max) begin
          skip_len = payload_len + 1;
          payload_len = 0;
          mode = ModeOscSkip;
        end else put_byte(b);
      end
      ModeOscEsc: begin
        if (b == StByte) begin
          drain();
          emit(KindOsc, '0, '0, '0, '0, '0);
          to_ground();
        end else if (payload_len + 1 >= osc_max) begin
          skip_len = payload_len + 2;
          payload_len = 0;
          mode = ModeOscSkip;
        end else begin
          put_byte(EscByte);
          put_byte(b);
          mode = ModeOsc;
        end
      end
      ModeOscSkip: begin
        bump_skip();
        if (b == BelByte) begin
          emit(KindUnknown, '0, '0, ClsOscOverflow, skip_len[15:0], '0);
          to_ground();
        end else if (b == EscByte) mode = ModeOscSkipEsc;
      end
      default: begin
        bump_skip();
        if (b == StByte) begin
          emit(KindUnknown, '0, '0, ClsOscOverflow, skip_len[15:0], '0);
          to_ground();
        end else mode = ModeOscSkip;
      end
    endcase
    if (due.size() > run_start) due[due.size() - 1].last = 1'b1;
  endfunction

  function bit differs(string name, logic [20:0] want, logic [20:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1'b1;
  endfunction

  function void check_item(item_t got);
    item_t want;
    bit    bad;
    seen[got.kind]++;
    if (due.size() == 0) begin
      errors++;
      $display("%0t: unexpected item, expected none, actual kind %0h", $time, got.kind);
      return;
    end
    want = due.pop_front();
    bad = differs("item_kind", 21'(want.kind), 21'(got.kind))
        | differs("code_point", want.cp, got.cp)
        | differs("final_code", 21'(want.fin), 21'(got.fin))
        | differs("unknown_class", 21'(want.cls), 21'(got.cls))
        | differs("discard_length", 21'(want.len), 21'(got.len))
        | differs("payload_value", 21'(want.pv), 21'(got.pv))
        | differs("last_of_run", 21'(want.last), 21'(got.last));
    if (bad) errors++;
  endfunction
endclass

module terminal_escape_utf8_parser_core_test;
  localparam int unsigned CsiMax = 32;
  localparam int unsigned OscMax = 32;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned HoldAt = 80;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 110;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  item_kind_o;
  logic [20:0] code_point_o;
  logic [7:0]  final_code_o;
  logic [1:0]  unknown_class_o;
  logic [15:0] discard_length_o;
  logic [7:0]  payload_value_o;
  logic        last_of_run_o;

  parse_scoreboard sb;
  int unsigned     in_count = 0;
  int unsigned     out_count = 0;
  int              idle_mode = 0;

  terminal_escape_utf8_parser_core #(
    .CSI_MAX_BYTES(CsiMax),
    .OSC_MAX_BYTES(OscMax)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .item_kind_o(item_kind_o),
    .code_point_o(code_point_o),
    .final_code_o(final_code_o),
    .unknown_class_o(unknown_class_o),
    .discard_length_o(discard_length_o),
    .payload_value_o(payload_value_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.take_byte(data_byte_i);
      in_count++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_item({item_kind_o, code_point_o, final_code_o, unknown_class_o,
                     discard_length_o, payload_value_o, last_of_run_o});
      out_count++;
    end
  end

  function bit sender_rests();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 17;
      1: return $urandom_range(0, 99) < 77;
      default: return 1'b0;
    endcase
  endfunction

  function bit receiver_rests();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 77;
      1: return $urandom_range(0, 99) < 17;
      default: return 1'b0;
    endcase
  endfunction

  // receiver side, with one long hold-off to back up the block
  initial begin : sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && in_count >= HoldAt) begin
        held = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else out_stall_i = receiver_rests();
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, QuietLimit);
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (sender_rests()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    data_byte_i = b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function logic [7:0] csi_param();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(8'h30, 8'h3f));
    else b = 8'($urandom_range(0, 255));
    if (b >= 8'h40 && b <= 8'h7e) b = b ^ 8'h40;
    return b;
  endfunction

  task automatic send_text();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = CrByte;
      1: b = LfByte;
      2: b = BsByte;
      3: b = TabByte;
      4: b = ($urandom_range(0, 1) != 0) ? DelByte : 8'($urandom_range(0, 8'h1a));
      default: b = 8'($urandom_range(8'h20, 8'h7e));
    endcase
    send_byte(b);
  endtask

  task automatic send_utf8(input bit broken);
    int unsigned tail;
    int unsigned break_at;
    logic [7:0]  b;
    tail = $urandom_range(1, 3);
    break_at = $urandom_range(0, tail - 1);
    case (tail)
      1: b = 8'($urandom_range(8'hc2, 8'hdf));
      2: b = 8'($urandom_range(8'he0, 8'hef));
      default: b = 8'($urandom_range(8'hf0, 8'hf4));
    endcase
    send_byte(b);
    for (int i = 0; i < tail; i++) begin
      if (broken && i == break_at) begin
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[7] = 1'b0;
        send_byte(b);
        break;
      end
      send_byte({2'b10, 6'($urandom_range(0, 63))});
    end
  endtask

  task automatic send_escape();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CsiOpen || b == OscOpen) b = b ^ 8'h80;
    send_byte(EscByte);
    send_byte(b);
  endtask

  task automatic send_csi();
    int unsigned n;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(CsiMax - 1, CsiMax + 5);
    else n = $urandom_range(0, 6);
    send_byte(EscByte);
    send_byte(CsiOpen);
    repeat (n) send_byte(csi_param());
    send_byte(8'($urandom_range(8'h40, 8'h7e)));
  endtask

  task automatic send_osc();
    int unsigned n;
    int unsigned stored;
    logic [7:0]  b;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(OscMax - 2, OscMax + 4);
    else n = $urandom_range(0, 8);
    send_byte(EscByte);
    send_byte(OscOpen);
    stored = 0;
    while (stored < n) begin
      if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom_range(0, 255));
        if (b == StByte) b = BelByte;
        send_byte(EscByte);
        send_byte(b);
        stored += 2;
      end else begin
        if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(8'h20, 8'h7e));
        else b = 8'($urandom_range(0, 255));
        if (b == BelByte || b == EscByte) b = b | 8'h40;
        send_byte(b);
        stored++;
      end
    end
    if ($urandom_range(0, 1) != 0) send_byte(BelByte);
    else begin
      send_byte(EscByte);
      send_byte(StByte);
    end
  endtask

  task automatic send_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) send_text();
    else if (pick < 30) send_utf8(1'b0);
    else if (pick < 36) send_utf8(1'b1);
    else if (pick < 44) send_escape();
    else if (pick < 68) send_csi();
    else if (pick < 90) send_osc();
    else send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    logic [7:0]  directed[$];
    int unsigned target;
    sb = new(CsiMax, OscMax);
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, controls, bad leads, 2 and 4 byte forms, bad continuation,
    // escape final, csi with parameters, osc with inner escape and st close
    directed = '{8'h20, 8'h7e, CrByte, LfByte, BsByte, TabByte, 8'h00, DelByte, 8'h80, 8'hff,
                 8'hc2, 8'h80, 8'hf4, 8'hbf, 8'hbf, 8'hbf, 8'hc3, 8'h41, EscByte, 8'h63,
                 EscByte, CsiOpen, 8'h31, 8'h6d, EscByte, OscOpen, 8'h41, EscByte, BelByte,
                 EscByte, StByte};
    foreach (directed[i]) send_byte(directed[i]);

    for (int ph = 0; ph < 3; ph++) begin
      idle_mode = ph;
      target = in_count + PhaseItems;
      while (in_count < target) send_sequence();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run: %0d bytes in, %0d items out, %0d mismatches", in_count, out_count, sb.errors);
    $display("run: %0d csi, %0d osc, %0d unknown, %0d payload, %0d print items",
             sb.seen[KindCsi], sb.seen[KindOsc], sb.seen[KindUnknown], sb.seen[KindPayload],
             sb.seen[KindPrint]);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- terminal_escape_utf8_parser_core.f -----
rtl/core/teup_pkg.sv
rtl/core/terminal_escape_utf8_parser_core.sv
tb/terminal_escape_utf8_parser_core_test.sv
